// ===== design/dhf_pkg.sv =====
// shared types and constants for the depth hole filler
package dhf_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned DIV_STEPS  = 16;
  localparam int unsigned DIV_CNT_W  = 4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_e;

  // corner order of one window: bottom-right, top-right, bottom-left, top-left
  typedef enum logic [1:0] {
    CORNER_BR = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BL = 2'd2,
    CORNER_TL = 2'd3
  } corner_e;

  typedef struct packed {
    logic        cmd;
    logic [15:0] pixel_value;
    logic [7:0]  read_row;
    logic [7:0]  read_col;
  } in_t;

  typedef struct packed {
    logic [15:0] filled_depth;
    logic        was_filled;
    logic        not_ready;
  } out_t;

  typedef struct packed {
    logic              ld_issue;
    logic              ld_write;
    logic              rd_start;
    logic              iss_v;
    logic [SLOT_W-1:0] iss_slot;
    logic              div_init;
    logic              div_step;
    logic              fin;
    logic              fin_nr;
  } ctrl_t;

  typedef struct packed {
    logic frame_done;
    logic found;
  } stat_t;

endpackage

// ===== design/dhf_datapath.sv =====
// integral tables, window sums and serial divider
module dhf_datapath #(
  parameter int unsigned MAX_WIDTH      = 256,
  parameter int unsigned MAX_HEIGHT     = 256,
  parameter int unsigned LARGEST_RADIUS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dhf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dhf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  dhf_pkg::in_t                      in_i,
  input  dhf_pkg::ctrl_t                    ctrl_i,
  output dhf_pkg::stat_t                    stat_o,
  output dhf_pkg::out_t                     res_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = 16 + AW;
  localparam int unsigned NW    = AW + 1;
  localparam int unsigned DWW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DHW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned XW0   = (DWW > DHW) ? DWW : DHW;
  localparam int unsigned XW    = ((XW0 > dhf_pkg::DIM_W) ? XW0 : dhf_pkg::DIM_W) + 1;
  localparam int unsigned SW1   = dhf_pkg::SLOT_W;

  // configuration
  logic [dhf_pkg::DIM_W-1:0] cfg_w_q, cfg_h_q;
  logic [15:0]               thr_q;

  // load position and row prefix
  logic [CW-1:0] ld_col_q;
  logic [RW-1:0] ld_row_q;
  logic [AW-1:0] ld_base_q;
  logic          fc_q;
  logic [SW-1:0] rp_s_q;
  logic [NW-1:0] rp_n_q;
  logic [15:0]   pix_q;
  logic          pv_q;

  // read side
  logic [RW-1:0] rr_q;
  logic [CW-1:0] rc_q;
  logic          iv_q, iz_q;
  logic [SW1-1:0] islot_q;
  logic [SW-1:0] acc_s_q, best_s_q;
  logic [NW-1:0] acc_n_q, best_n_q;
  logic          found_q;
  logic [15:0]   pixr_q;
  logic [NW-1:0] rem_q;
  logic [15:0]   qd_q;
  dhf_pkg::out_t res_q;

  // memories
  logic [SW-1:0] sum_mem [DEPTH];
  logic [NW-1:0] cnt_mem [DEPTH];
  logic [15:0]   pix_mem [DEPTH];
  logic [SW-1:0] rd_s_q;
  logic [NW-1:0] rd_n_q;
  logic [15:0]   rd_p_q;

  logic [XW-1:0] wx, hx, eff_w, eff_h, last_c, last_r;
  logic [XW-1:0] rx_in, cx_in;
  logic [AW-1:0] ld_addr, raddr, corner_addr;
  logic [SW-1:0] up_s, rp_s_new, wr_s;
  logic [NW-1:0] up_n, rp_n_new, wr_n;
  logic          last_col, last_row;

  always_comb begin
    wx = XW'(cfg_w_q);
    hx = XW'(cfg_h_q);
    if (wx == '0) begin
      eff_w = XW'(1);
    end else if (wx > XW'(MAX_WIDTH)) begin
      eff_w = XW'(MAX_WIDTH);
    end else begin
      eff_w = wx;
    end
    if (hx == '0) begin
      eff_h = XW'(1);
    end else if (hx > XW'(MAX_HEIGHT)) begin
      eff_h = XW'(MAX_HEIGHT);
    end else begin
      eff_h = hx;
    end
    last_c = eff_w - XW'(1);
    last_r = eff_h - XW'(1);
  end

  // load arithmetic: entry = entry above + running row prefix
  always_comb begin
    ld_addr  = ld_base_q + AW'(ld_col_q);
    up_s     = (ld_row_q != '0) ? rd_s_q : '0;
    up_n     = (ld_row_q != '0) ? rd_n_q : '0;
    rp_s_new = ((ld_col_q == '0) ? '0 : rp_s_q) + (pv_q ? SW'(pix_q) : '0);
    rp_n_new = ((ld_col_q == '0) ? '0 : rp_n_q) + (pv_q ? NW'(1) : '0);
    wr_s     = up_s + rp_s_new;
    wr_n     = up_n + rp_n_new;
    last_col = (XW'(ld_col_q) == last_c);
    last_row = (XW'(ld_row_q) == last_r);
  end

  // window corner address for the current issue slot
  logic [SW1-1:0]   s1;
  dhf_pkg::corner_e corner;
  logic [XW-1:0]    rad, rowx, colx, top, bot, lft, rgt, ar, ac;
  logic             zero_c;

  always_comb begin
    s1     = ctrl_i.iss_slot - SW1'(1);
    corner = dhf_pkg::corner_e'(s1[1:0]);
    rad    = XW'(LARGEST_RADIUS) >> s1[SW1-1:2];
    rowx   = XW'(rr_q);
    colx   = XW'(rc_q);
    top    = (rowx > rad) ? rowx - rad : '0;
    lft    = (colx > rad) ? colx - rad : '0;
    bot    = ((last_r - rowx) > rad) ? rowx + rad : last_r;
    rgt    = ((last_c - colx) > rad) ? colx + rad : last_c;
    ar     = bot;
    ac     = rgt;
    zero_c = 1'b0;
    case (corner)
      dhf_pkg::CORNER_BR: begin
        ar = bot;
        ac = rgt;
      end
      dhf_pkg::CORNER_TR: begin
        ar     = top - XW'(1);
        ac     = rgt;
        zero_c = (top == '0);
      end
      dhf_pkg::CORNER_BL: begin
        ar     = bot;
        ac     = lft - XW'(1);
        zero_c = (lft == '0);
      end
      dhf_pkg::CORNER_TL: begin
        ar     = top - XW'(1);
        ac     = lft - XW'(1);
        zero_c = (top == '0) || (lft == '0);
      end
      default: begin
        ar = bot;
        ac = rgt;
      end
    endcase
    if (ctrl_i.iss_slot == '0) begin
      ar     = rowx;
      ac     = colx;
      zero_c = 1'b0;
    end
    corner_addr = AW'(ar[RW-1:0]) * AW'(MAX_WIDTH) + AW'(ac[CW-1:0]);
    raddr       = ctrl_i.ld_issue ? ld_addr - AW'(MAX_WIDTH) : corner_addr;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_write) begin
      sum_mem[ld_addr] <= wr_s;
      cnt_mem[ld_addr] <= wr_n;
      pix_mem[ld_addr] <= pix_q;
    end
    rd_s_q <= sum_mem[raddr];
    rd_n_q <= cnt_mem[raddr];
    rd_p_q <= pix_mem[raddr];
  end

  // config and load position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= dhf_pkg::DIM_W'(256);
      cfg_h_q   <= dhf_pkg::DIM_W'(256);
      thr_q     <= '0;
      ld_col_q  <= '0;
      ld_row_q  <= '0;
      ld_base_q <= '0;
      fc_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (dhf_pkg::cfg_idx_e'(cfg_idx_i))
        dhf_pkg::CFG_WIDTH: begin
          cfg_w_q   <= cfg_data_i[dhf_pkg::DIM_W-1:0];
          ld_col_q  <= '0;
          ld_row_q  <= '0;
          ld_base_q <= '0;
          fc_q      <= 1'b0;
        end
        dhf_pkg::CFG_HEIGHT: begin
          cfg_h_q   <= cfg_data_i[dhf_pkg::DIM_W-1:0];
          ld_col_q  <= '0;
          ld_row_q  <= '0;
          ld_base_q <= '0;
          fc_q      <= 1'b0;
        end
        dhf_pkg::CFG_THRESH: begin
          thr_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end else if (ctrl_i.ld_write) begin
      if (last_col) begin
        ld_col_q <= '0;
        if (last_row) begin
          ld_row_q  <= '0;
          ld_base_q <= '0;
          fc_q      <= 1'b1;
        end else begin
          ld_row_q  <= ld_row_q + RW'(1);
          ld_base_q <= ld_base_q + AW'(MAX_WIDTH);
        end
      end else begin
        ld_col_q <= ld_col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_issue) begin
      pix_q <= in_i.pixel_value;
      pv_q  <= (in_i.pixel_value > thr_q);
    end
    if (ctrl_i.ld_write) begin
      rp_s_q <= rp_s_new;
      rp_n_q <= rp_n_new;
    end
  end

  // read position clamp
  logic [XW-1:0] row_cl, col_cl;
  always_comb begin
    rx_in  = XW'(in_i.read_row);
    cx_in  = XW'(in_i.read_col);
    row_cl = (rx_in > last_r) ? last_r : rx_in;
    col_cl = (cx_in > last_c) ? last_c : cx_in;
  end

  // corner accumulation, one word per cycle behind the issue
  logic [SW1-1:0]   d1;
  dhf_pkg::corner_e dcorner;
  logic [SW-1:0]    term_s, base_s, new_s;
  logic [NW-1:0]    term_n, base_n, new_n;
  logic             neg;

  always_comb begin
    d1      = islot_q - SW1'(1);
    dcorner = dhf_pkg::corner_e'(d1[1:0]);
    term_s  = iz_q ? '0 : rd_s_q;
    term_n  = iz_q ? '0 : rd_n_q;
    base_s  = (dcorner == dhf_pkg::CORNER_BR) ? '0 : acc_s_q;
    base_n  = (dcorner == dhf_pkg::CORNER_BR) ? '0 : acc_n_q;
    neg     = (dcorner == dhf_pkg::CORNER_TR) || (dcorner == dhf_pkg::CORNER_BL);
    new_s   = neg ? base_s - term_s : base_s + term_s;
    new_n   = neg ? base_n - term_n : base_n + term_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      iv_q <= ctrl_i.iss_v;
      if (ctrl_i.rd_start) begin
        found_q <= 1'b0;
      end else if (iv_q && islot_q != '0 && dcorner == dhf_pkg::CORNER_TL && new_n != '0) begin
        found_q <= 1'b1;
      end
    end
  end

  // serial divider: quotient fits 16 bits, so the top bits seed the remainder
  logic [NW:0] dv_t;
  logic        dv_ge;
  always_comb begin
    dv_t  = {rem_q, qd_q[15]};
    dv_ge = (dv_t >= {1'b0, best_n_q});
  end

  always_ff @(posedge clk_i) begin
    islot_q <= ctrl_i.iss_slot;
    iz_q    <= zero_c;
    if (ctrl_i.rd_start) begin
      rr_q <= row_cl[RW-1:0];
      rc_q <= col_cl[CW-1:0];
    end
    if (iv_q) begin
      if (islot_q == '0) begin
        pixr_q <= rd_p_q;
      end else begin
        acc_s_q <= new_s;
        acc_n_q <= new_n;
        if (dcorner == dhf_pkg::CORNER_TL && new_n != '0) begin
          best_s_q <= new_s;
          best_n_q <= new_n;
        end
      end
    end
    if (ctrl_i.div_init) begin
      rem_q <= NW'(best_s_q >> 16);
      qd_q  <= best_s_q[15:0];
    end else if (ctrl_i.div_step) begin
      rem_q <= dv_ge ? NW'(dv_t - {1'b0, best_n_q}) : dv_t[NW-1:0];
      qd_q  <= {qd_q[14:0], dv_ge};
    end
    if (ctrl_i.fin) begin
      res_q.filled_depth <= found_q ? qd_q : pixr_q;
      res_q.was_filled   <= found_q;
      res_q.not_ready    <= 1'b0;
    end else if (ctrl_i.fin_nr) begin
      res_q.filled_depth <= '0;
      res_q.was_filled   <= 1'b0;
      res_q.not_ready    <= 1'b1;
    end
  end

  assign stat_o.frame_done = fc_q;
  assign stat_o.found      = found_q;
  assign res_o             = res_q;

endmodule

// ===== design/dhf_ctrl.sv =====
// sequencer for loads, window fetches and the divider
module dhf_ctrl #(
  parameter int unsigned LARGEST_RADIUS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           cmd_i,
  input  dhf_pkg::stat_t stat_i,
  output dhf_pkg::ctrl_t ctrl_o,
  output logic           busy,
  output logic           done_o
);

  localparam int unsigned NR     = $clog2(LARGEST_RADIUS);
  localparam int unsigned NSLOTS = 1 + 4 * NR;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LD_WR  = 8'b0000_0010,
    S_RD_ISS = 8'b0000_0100,
    S_RD_DRN = 8'b0000_1000,
    S_RD_CHK = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_FIN    = 8'b0100_0000,
    S_NR     = 8'b1000_0000
  } state_e;

  state_e                         state_q, state_d;
  logic [dhf_pkg::SLOT_W-1:0]     slot_q, slot_d;
  logic [dhf_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic                           done_q, done_d;

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    ctrl_o  = '0;
    ctrl_o.iss_slot = slot_q;
    case (state_q)
      S_IDLE: begin
        slot_d = '0;
        if (start) begin
          if (cmd_i == dhf_pkg::CMD_LOAD) begin
            ctrl_o.ld_issue = 1'b1;
            state_d         = S_LD_WR;
          end else begin
            ctrl_o.rd_start = 1'b1;
            state_d         = stat_i.frame_done ? S_RD_ISS : S_NR;
          end
        end
      end
      S_LD_WR: begin
        ctrl_o.ld_write = 1'b1;
        state_d         = S_IDLE;
      end
      S_RD_ISS: begin
        ctrl_o.iss_v = 1'b1;
        if (slot_q == dhf_pkg::SLOT_W'(NSLOTS - 1)) begin
          state_d = S_RD_DRN;
        end else begin
          slot_d = slot_q + dhf_pkg::SLOT_W'(1);
        end
      end
      S_RD_DRN: begin
        state_d = S_RD_CHK;
      end
      S_RD_CHK: begin
        if (stat_i.found) begin
          ctrl_o.div_init = 1'b1;
          cnt_d           = '0;
          state_d         = S_DIV;
        end else begin
          ctrl_o.fin = 1'b1;
          done_d     = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_DIV: begin
        ctrl_o.div_step = 1'b1;
        cnt_d           = cnt_q + dhf_pkg::DIV_CNT_W'(1);
        if (cnt_q == dhf_pkg::DIV_CNT_W'(dhf_pkg::DIV_STEPS - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        ctrl_o.fin = 1'b1;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      S_NR: begin
        ctrl_o.fin_nr = 1'b1;
        done_d        = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== design/depth_hole_fill_box_average.sv =====
// top level of the depth hole filler
//
// channel   direction  handshake               word
// command   in         start high, busy low    in_i
// result    out        done_o strobe, 1 cycle  res_o
// config    in         cfg_we_i high           cfg_idx_i, cfg_data_i
//
// a load reads the entry one row up, then writes the table
// a read keeps busy high after the accept while it issues the window fetches,
// drains and checks, then while the bit-serial divider runs when a window holds
// valid pixels; the result comes on done_o in the same cycle that busy falls
// reset sets control and configuration to defaults; tables hold garbage until loaded
// the result receiver cannot stall, each word is flagged by done_o for one cycle only
module depth_hole_fill_box_average #(
  parameter int unsigned MAX_WIDTH      = 256,
  parameter int unsigned MAX_HEIGHT     = 256,
  parameter int unsigned LARGEST_RADIUS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  dhf_pkg::in_t                   in_i,
  output logic                           done_o,
  output dhf_pkg::out_t                  res_o,
  input  logic                           cfg_we_i,
  input  logic [dhf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dhf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  dhf_pkg::ctrl_t ctrl;
  dhf_pkg::stat_t stat;

  dhf_ctrl #(
    .LARGEST_RADIUS(LARGEST_RADIUS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (in_i.cmd),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy),
    .done_o (done_o)
  );

  dhf_datapath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .LARGEST_RADIUS(LARGEST_RADIUS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_i),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .res_o     (res_o)
  );

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result word without preceding work");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result word repeated");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.cmd == dhf_pkg::CMD_LOAD) |=> !done_o)
    else $error("load produced a result word");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(res_o.was_filled && res_o.not_ready))
    else $error("filled result flagged not ready");
`endif

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the depth hole filler with a built-in box average predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_CELLS = 65536;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned STALL_LIMIT = 5000;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  dhf_pkg::in_t  in_i;
  logic          done_o;
  dhf_pkg::out_t res_o;
  logic          cfg_we_i;
  logic [dhf_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [dhf_pkg::CFG_DATA_W-1:0] cfg_data_i;

  depth_hole_fill_box_average uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
    .done_o(done_o), .res_o(res_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // predictor state
  logic [15:0]     depth_store [FRAME_CELLS];
  longint unsigned integral_sum [FRAME_CELLS];
  int unsigned     integral_count [FRAME_CELLS];
  int unsigned     next_pixel;
  bit              frame_loaded;
  logic [8:0]      width_reg;
  logic [8:0]      height_reg;
  logic [15:0]     thresh_reg;

  dhf_pkg::out_t pending_depths[$];
  int unsigned word_count;
  int unsigned load_count;
  int unsigned read_count;
  int unsigned filled_count;
  int unsigned result_count;
  int unsigned error_count;
  int unsigned idle_cycles;
  bit          no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > 256) return 256;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    if (height_reg == 0) return 1;
    if (height_reg > 256) return 256;
    return height_reg;
  endfunction

  function automatic longint unsigned sum_corner(int unsigned r1, int unsigned c1);
    if (r1 == 0 || c1 == 0) return 0;
    return integral_sum[(r1 - 1) * 256 + c1 - 1];
  endfunction

  function automatic int unsigned count_corner(int unsigned r1, int unsigned c1);
    if (r1 == 0 || c1 == 0) return 0;
    return integral_count[(r1 - 1) * 256 + c1 - 1];
  endfunction

  function automatic void store_pixel(logic [15:0] value);
    int unsigned w, h, r, c, idx;
    bit          valid;
    w = eff_w();
    h = eff_h();
    valid = value > thresh_reg;
    if (next_pixel >= w * h) next_pixel = 0;
    r = next_pixel / w;
    c = next_pixel % w;
    idx = r * 256 + c;
    depth_store[idx] = value;
    integral_sum[idx] = (valid ? longint'(value) : 0) + sum_corner(r, c + 1)
                        + sum_corner(r + 1, c) - sum_corner(r, c);
    integral_count[idx] = (valid ? 1 : 0) + count_corner(r, c + 1)
                          + count_corner(r + 1, c) - count_corner(r, c);
    next_pixel++;
    if (next_pixel >= w * h) begin
      next_pixel = 0;
      frame_loaded = 1'b1;
    end
  endfunction

  function automatic dhf_pkg::out_t fill_depth(logic [7:0] rd_row, logic [7:0] rd_col);
    dhf_pkg::out_t   res;
    int unsigned     w, h, row, col, top, lft, bot, rgt, n;
    longint unsigned s;
    res = '0;
    if (!frame_loaded) begin
      res.not_ready = 1'b1;
      return res;
    end
    w = eff_w();
    h = eff_h();
    row = (rd_row > h - 1) ? h - 1 : rd_row;
    col = (rd_col > w - 1) ? w - 1 : rd_col;
    res.filled_depth = depth_store[row * 256 + col];
    // smallest window holding a valid pixel wins
    for (int unsigned rad = 8; rad >= 2; rad = rad >> 1) begin
      top = row > rad ? row - rad : 0;
      lft = col > rad ? col - rad : 0;
      bot = (h - 1 - row > rad) ? row + rad : h - 1;
      rgt = (w - 1 - col > rad) ? col + rad : w - 1;
      s = sum_corner(bot + 1, rgt + 1) - sum_corner(top, rgt + 1)
          - sum_corner(bot + 1, lft) + sum_corner(top, lft);
      n = count_corner(bot + 1, rgt + 1) - count_corner(top, rgt + 1)
          - count_corner(bot + 1, lft) + count_corner(top, lft);
      if (n != 0) begin
        res.filled_depth = 16'(s / n);
        res.was_filled = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_word(logic cmd, logic [15:0] pix, logic [7:0] row, logic [7:0] col);
    dhf_pkg::in_t w;
    int unsigned  gap;
    w.cmd = cmd;
    w.pixel_value = pix;
    w.read_row = row;
    w.read_col = col;
    @(negedge clk_i);
    start <= 1'b1;
    in_i <= w;
    do @(posedge clk_i); while (busy);
    word_count++;
    if (cmd == dhf_pkg::CMD_LOAD) begin
      load_count++;
      store_pixel(pix);
    end else begin
      read_count++;
      pending_depths.insert(pending_depths.size(), fill_depth(row, col));
    end
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic load_word(logic [15:0] pix);
    send_word(dhf_pkg::CMD_LOAD, pix, 8'($urandom), 8'($urandom));
  endtask

  task automatic read_word(logic [7:0] row, logic [7:0] col);
    send_word(dhf_pkg::CMD_READ, 16'($urandom), row, col);
  endtask

  // sender holds off until the block is quiet
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_depths.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(dhf_pkg::cfg_idx_e idx, logic [15:0] data);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      dhf_pkg::CFG_WIDTH: begin
        width_reg = data[8:0];
        next_pixel = 0;
        frame_loaded = 1'b0;
      end
      dhf_pkg::CFG_HEIGHT: begin
        height_reg = data[8:0];
        next_pixel = 0;
        frame_loaded = 1'b0;
      end
      dhf_pkg::CFG_THRESH: thresh_reg = data;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] random_depth();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return 16'h0000;
    if (roll == 3) return 16'hffff;
    return 16'($urandom);
  endfunction

  task automatic load_frame();
    repeat (eff_w() * eff_h()) load_word(random_depth());
  endtask

  task automatic test_not_ready();
    read_word(8'd0, 8'd0);
    read_word(8'd255, 8'd255);
    load_word(16'hffff);
    read_word(8'd0, 8'd255);
  endtask

  task automatic test_single_pixel();
    write_reg(dhf_pkg::CFG_WIDTH, 16'd1);
    write_reg(dhf_pkg::CFG_HEIGHT, 16'd1);
    write_reg(dhf_pkg::CFG_THRESH, 16'd0);
    load_word(16'd0);                 // not above threshold, original value
    read_word(8'd0, 8'd0);
    load_word(16'hffff);
    read_word(8'd255, 8'd255);        // clamps to the only pixel
  endtask

  task automatic test_wide_and_tall();
    write_reg(dhf_pkg::CFG_WIDTH, 16'd256);
    write_reg(dhf_pkg::CFG_HEIGHT, 16'd1);
    load_frame();
    read_word(8'd0, 8'd0);
    read_word(8'd0, 8'd255);
    read_word(8'd200, 8'd128);
    write_reg(dhf_pkg::CFG_WIDTH, 16'd1);
    write_reg(dhf_pkg::CFG_HEIGHT, 16'd256);
    load_frame();
    read_word(8'd255, 8'd0);
    read_word(8'd0, 8'd77);
  endtask

  task automatic test_threshold_edges();
    write_reg(dhf_pkg::CFG_WIDTH, 16'h0000);   // saturates up to one column
    write_reg(dhf_pkg::CFG_HEIGHT, 16'h01ff);  // saturates down to 256 rows
    write_reg(dhf_pkg::CFG_THRESH, 16'hffff);  // nothing can be valid
    repeat (40) load_word(16'($urandom));
    write_reg(dhf_pkg::CFG_WIDTH, 16'd5);
    write_reg(dhf_pkg::CFG_HEIGHT, 16'd4);
    load_frame();
    read_word(8'd2, 8'd3);
    // same value rewritten still restarts the frame
    write_reg(dhf_pkg::CFG_WIDTH, 16'd5);
    read_word(8'd1, 8'd1);
    // threshold moved halfway through a frame
    write_reg(dhf_pkg::CFG_THRESH, 16'h7fff);
    repeat (10) load_word(16'($urandom));
    write_reg(dhf_pkg::CFG_THRESH, 16'h0000);
    repeat (10) load_word(16'($urandom));
    read_word(8'd3, 8'd4);
    read_word(8'd0, 8'd0);
  endtask

  task automatic test_random_frames();
    int unsigned reads;
    int unsigned other_max;
    logic [15:0] dim;
    while (word_count < 2000) begin
      case ($urandom_range(0, 9))
        0: dim = 16'd256;
        1: dim = 16'($urandom);       // out of range values saturate
        default: dim = 16'($urandom_range(1, 20));
      endcase
      // keep long frames narrow in the other direction
      other_max = (dim[8:0] > 9'd20) ? 3 : 20;
      if ($urandom_range(0, 1)) begin
        write_reg(dhf_pkg::CFG_WIDTH, dim);
        write_reg(dhf_pkg::CFG_HEIGHT, 16'($urandom_range(1, other_max)));
      end else begin
        write_reg(dhf_pkg::CFG_HEIGHT, dim);
        write_reg(dhf_pkg::CFG_WIDTH, 16'($urandom_range(1, other_max)));
      end
      case ($urandom_range(0, 3))
        0: write_reg(dhf_pkg::CFG_THRESH, 16'h0000);
        1: write_reg(dhf_pkg::CFG_THRESH, 16'hffff);
        default: write_reg(dhf_pkg::CFG_THRESH, 16'($urandom));
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) read_word(8'($urandom), 8'($urandom));
      load_frame();
      // reads mixed with loads that start overwriting the next frame
      reads = $urandom_range(10, 40);
      while (reads > 0) begin
        if ($urandom_range(0, 9) < 7) begin
          read_word(8'($urandom), 8'($urandom));
          reads--;
        end else begin
          load_word(random_depth());
        end
      end
      no_gaps = 1'b0;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      result_count++;
      if (pending_depths.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result %h", $time, res_o);
      end else begin
        automatic dhf_pkg::out_t exp = pending_depths.pop_front();
        if (exp.was_filled) filled_count++;
        if (res_o.filled_depth !== exp.filled_depth || res_o.was_filled !== exp.was_filled
            || res_o.not_ready !== exp.not_ready) begin
          error_count++;
          $display("%0t: mismatch expected depth %h filled %b not_ready %b, got %h %b %b",
                   $time, exp.filled_depth, exp.was_filled, exp.not_ready,
                   res_o.filled_depth, res_o.was_filled, res_o.not_ready);
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("** depth_hole_fill_box_average: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = dhf_pkg::CFG_WIDTH;
    cfg_data_i = '0;
    idle_cycles = 0;
    word_count = 0;
    load_count = 0;
    read_count = 0;
    filled_count = 0;
    result_count = 0;
    error_count = 0;
    no_gaps = 1'b0;
    next_pixel = 0;
    frame_loaded = 1'b0;
    width_reg = 9'd256;
    height_reg = 9'd256;
    thresh_reg = 16'd0;
    for (int i = 0; i < FRAME_CELLS; i++) begin
      depth_store[i] = '0;
      integral_sum[i] = 0;
      integral_count[i] = 0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_not_ready();
    test_single_pixel();
    test_wide_and_tall();
    test_threshold_edges();
    test_random_frames();
    drain();

    $display("covered %0d loads and %0d reads, %0d results checked, %0d from window averages",
             load_count, read_count, result_count, filled_count);
    $display("frame sizes from 1x1 to 256 wide or tall, thresholds at both extremes");
    if (error_count == 0) begin
      $display("** depth_hole_fill_box_average: PASSED **");
    end else begin
      $display("** depth_hole_fill_box_average: FAILED **");
    end
    $finish;
  end

endmodule
